// ----- sv/mct_pkg.sv -----
package mct_pkg;

   localparam int SAMPLE_RATE_DEFAULT = 48000;
   localparam logic [31:0] TICKS_PER_SECOND = 32'd10_000_000;
   localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

   localparam int DIVIDEND_W = 64;
   localparam int DIVISOR_W = 32;
   localparam int DIV_CNT_W = $clog2(DIVIDEND_W);

   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_UPDATE = 3'd1;
   localparam logic [2:0] OP_STOP = 3'd2;
   localparam logic [2:0] OP_FAIL = 3'd3;
   localparam logic [2:0] OP_PROJECT = 3'd4;

   localparam logic [2:0] CSR_FREQUENCY = 3'd0;
   localparam logic [2:0] CSR_ANCHOR_POSITION = 3'd1;
   localparam logic [2:0] CSR_ANCHOR_MEDIA = 3'd2;
   localparam logic [2:0] CSR_ANCHOR_GENERATION = 3'd3;

   typedef struct packed {
      logic [2:0] opcode;
      logic [63:0] device_position;
      logic [63:0] time_100ns;
      logic [31:0] generation;
   } req_word_type;

   typedef struct packed {
      logic accepted;
      logic [62:0] media_position;
      logic [62:0] extrapolated_samples;
      logic [62:0] projected_sample;
      logic [31:0] clock_generation;
      logic running_flag;
      logic [31:0] mismatch_count;
      logic [31:0] regression_count;
      logic [31:0] failure_count;
   } rsp_word_type;

   typedef struct packed {
      logic load_item;
      logic do_check;
      logic div_start;
      logic div_second;
      logic mul1;
      logic mul2;
      logic fin1;
      logic fin2;
      logic emit;
   } mct_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
      logic rsp_free;
   } mct_status_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] c);
      return (c == MAX32) ? c : c + 32'd1;
   endfunction

endpackage

// ----- sv/mct_divider.sv -----
module mct_divider
   import mct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W:0]    shifted;
   logic                  ge;

   // One quotient bit per cycle, restoring form.
   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign ge = shifted >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= ge ? DIVISOR_W'(shifted - {1'b0, divisor}) : shifted[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- sv/mct_datapath.sv -----
module mct_datapath
   import mct_pkg::*;
#(
   parameter int SAMPLE_RATE = SAMPLE_RATE_DEFAULT
)
(
   input  logic           clock,
   input  logic           reset,
   input  mct_cmd_type    cmd,
   output mct_status_type status,
   input  req_word_type   req_word,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_word_type   rsp_word,
   input  logic           csr_write,
   input  logic [2:0]     csr_index,
   input  logic [63:0]    csr_data
);

   localparam int RATE_W = $clog2(SAMPLE_RATE + 1);
   localparam int PROD_W = DIVISOR_W + RATE_W;
   localparam logic [RATE_W-1:0] RATE_V = RATE_W'(SAMPLE_RATE);
   localparam logic [63:0] WHOLE_MAX = MAX63 / 64'(SAMPLE_RATE);

   logic [31:0] cfg_freq_ff, cfg_gen_ff;
   logic [63:0] cfg_pos_ff;
   logic [62:0] cfg_media_ff;

   logic        running_ff;
   logic [63:0] last_time_ff;
   logic [62:0] stored_ff;
   logic [31:0] lgen_ff, mism_ff, regr_ff, fail_ff, lat_freq_ff;
   logic [63:0] lat_pos_ff;
   logic [62:0] lat_media_ff;

   req_word_type item_ff;

   logic              is_upd_ff, ovf_ff, bad_ff, acc_ff;
   logic [31:0]       divisor_ff;
   logic [PROD_W-1:0] prod_lo_ff, prod_hi_ff, prod_rem_ff;
   logic [63:0]       base_ff, sum1_ff;
   logic [62:0]       ext_ff, proj_ff;

   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   logic        upd_go, prj_go;
   logic        div_done;
   logic [63:0] quo;
   logic [31:0] rem;
   logic [63:0] dividend;
   logic [63:0] addend, sum2;
   logic        fail2;

   assign upd_go = running_ff && item_ff.generation == lgen_ff
                   && item_ff.device_position >= lat_pos_ff && lat_freq_ff != 32'd0;
   assign prj_go = running_ff && lat_freq_ff != 32'd0 && item_ff.generation != 32'd0
                   && item_ff.generation == lgen_ff && item_ff.time_100ns >= last_time_ff;

   assign dividend = cmd.div_second ? 64'(prod_rem_ff)
                   : is_upd_ff ? item_ff.device_position - lat_pos_ff
                   : item_ff.time_100ns - last_time_ff;

   mct_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (divisor_ff),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   assign addend = is_upd_ff ? {1'b0, lat_media_ff} : 64'd0;
   assign sum2 = sum1_ff + quo;
   assign fail2 = bad_ff || quo > MAX63 - sum1_ff;

   assign status.need_div = (item_ff.opcode == OP_UPDATE && upd_go)
                         || (item_ff.opcode == OP_PROJECT && prj_go);
   assign status.div_done = div_done;
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_word;
      end
      if (cmd.do_check) begin
         is_upd_ff <= item_ff.opcode == OP_UPDATE;
         divisor_ff <= (item_ff.opcode == OP_UPDATE) ? lat_freq_ff : TICKS_PER_SECOND;
      end
      if (cmd.mul1) begin
         prod_lo_ff <= quo[31:0] * RATE_V;
         prod_hi_ff <= quo[63:32] * RATE_V;
         ovf_ff <= quo > WHOLE_MAX;
      end
      if (cmd.mul2) begin
         base_ff <= 64'(prod_lo_ff) + (64'(prod_hi_ff) << 32);
         prod_rem_ff <= rem * RATE_V;
      end
      if (cmd.fin1) begin
         bad_ff <= ovf_ff || base_ff > MAX63 - addend;
         sum1_ff <= addend + base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_freq_ff <= '0;
         cfg_pos_ff <= '0;
         cfg_media_ff <= '0;
         cfg_gen_ff <= '0;
         running_ff <= 1'b0;
         last_time_ff <= '0;
         stored_ff <= '0;
         lgen_ff <= '0;
         mism_ff <= '0;
         regr_ff <= '0;
         fail_ff <= '0;
         lat_freq_ff <= '0;
         lat_pos_ff <= '0;
         lat_media_ff <= '0;
         acc_ff <= 1'b0;
         ext_ff <= '0;
         proj_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_FREQUENCY: cfg_freq_ff <= csr_data[31:0];
               CSR_ANCHOR_POSITION: cfg_pos_ff <= csr_data;
               CSR_ANCHOR_MEDIA: cfg_media_ff <= csr_data[62:0];
               CSR_ANCHOR_GENERATION: cfg_gen_ff <= csr_data[31:0];
               default: ;
            endcase
         end
         if (cmd.do_check) begin
            acc_ff <= 1'b0;
            ext_ff <= '0;
            proj_ff <= '0;
            case (item_ff.opcode)
               OP_START: begin
                  if (cfg_freq_ff != 32'd0 && cfg_gen_ff != 32'd0) begin
                     lat_freq_ff <= cfg_freq_ff;
                     lat_pos_ff <= cfg_pos_ff;
                     lat_media_ff <= cfg_media_ff;
                     last_time_ff <= item_ff.time_100ns;
                     stored_ff <= cfg_media_ff;
                     lgen_ff <= cfg_gen_ff;
                     running_ff <= 1'b1;
                     acc_ff <= 1'b1;
                  end
               end
               OP_UPDATE: begin
                  if (running_ff) begin
                     if (item_ff.generation != lgen_ff) begin
                        mism_ff <= sat_inc(mism_ff);
                     end else if (!upd_go) begin
                        regr_ff <= sat_inc(regr_ff);
                     end
                  end
               end
               OP_STOP: running_ff <= 1'b0;
               OP_FAIL: fail_ff <= sat_inc(fail_ff);
               default: ;
            endcase
         end
         if (cmd.fin2) begin
            if (is_upd_ff) begin
               if (fail2 || sum2 < {1'b0, stored_ff}) begin
                  regr_ff <= sat_inc(regr_ff);
               end else begin
                  stored_ff <= sum2[62:0];
                  last_time_ff <= item_ff.time_100ns;
                  acc_ff <= 1'b1;
               end
            end else if (!(fail2 || sum2 > MAX63 - {1'b0, stored_ff})) begin
               acc_ff <= 1'b1;
               ext_ff <= sum2[62:0];
               proj_ff <= stored_ff + sum2[62:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_word_ff.accepted <= acc_ff;
         rsp_word_ff.media_position <= stored_ff;
         rsp_word_ff.extrapolated_samples <= ext_ff;
         rsp_word_ff.projected_sample <= proj_ff;
         rsp_word_ff.clock_generation <= lgen_ff;
         rsp_word_ff.running_flag <= running_ff;
         rsp_word_ff.mismatch_count <= mism_ff;
         rsp_word_ff.regression_count <= regr_ff;
         rsp_word_ff.failure_count <= fail_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

endmodule

// ----- sv/mct_control.sv -----
module mct_control
   import mct_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  mct_status_type status,
   output mct_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_DIV1_START = 4'd2;
   localparam logic [3:0] ST_DIV1_WAIT = 4'd3;
   localparam logic [3:0] ST_MUL1 = 4'd4;
   localparam logic [3:0] ST_MUL2 = 4'd5;
   localparam logic [3:0] ST_DIV2_START = 4'd6;
   localparam logic [3:0] ST_DIV2_WAIT = 4'd7;
   localparam logic [3:0] ST_FIN1 = 4'd8;
   localparam logic [3:0] ST_FIN2 = 4'd9;
   localparam logic [3:0] ST_EMIT = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.do_check = 1'b1;
            state_in = status.need_div ? ST_DIV1_START : ST_EMIT;
         end
         ST_DIV1_START: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV1_WAIT;
         end
         ST_DIV1_WAIT: begin
            if (status.div_done) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_DIV2_START;
         end
         ST_DIV2_START: begin
            cmd.div_start = 1'b1;
            cmd.div_second = 1'b1;
            state_in = ST_DIV2_WAIT;
         end
         ST_DIV2_WAIT: begin
            if (status.div_done) begin
               state_in = ST_FIN1;
            end
         end
         ST_FIN1: begin
            cmd.fin1 = 1'b1;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            cmd.fin2 = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.rsp_free)
      else $error("result written while output register is occupied");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_CHECK)
      else $error("accepted word not checked next cycle");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV1_WAIT && status.div_done) |=> state_ff == ST_MUL1)
      else $error("first division result not consumed");

endmodule

// ----- sv/media_clock_tracker.sv -----
// Media sample clock tracker anchored to a device position counter.
// Request words carry an opcode (start, update, stop, note failure, project)
// with a device position, a 100 ns timestamp and a generation tag. Every
// request word yields exactly one response word with the accept flag, the
// stored media position, the projection and the saturating counters.
// The user is to write configuration registers only while the block is idle
// (not enforced: csr_ready is always high); unknown-index writes are dropped.
// Start, stop, failure notes, unused opcodes, and updates or projections
// refused at the first checks go from the check state straight to the emit
// state. Other updates and projections run two 64-step passes through one
// shared restoring divider before the emit state, and the next word can be
// taken once the controller has returned to its idle state; that divider
// sets the throughput. One request is worked on at a time, and req_stall is
// high until its response has been written into the output register. While
// rsp_stall holds an earlier response there, a finished request waits in the
// final state until the output register is free.
// Reset clears the clock state, counters, anchors and the response valid flag.
module media_clock_tracker
   import mct_pkg::*;
#(
   parameter int SAMPLE_RATE = SAMPLE_RATE_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   mct_cmd_type    cmd;
   mct_status_type status;

   // Configuration is taken whenever offered.
   assign csr_ready = 1'b1;

   mct_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mct_datapath #(
      .SAMPLE_RATE (SAMPLE_RATE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
